[design/wegs_pkg.sv]
package wegs_pkg;

  // Configuration register indexes
  typedef enum logic [7:0] {
    CFG_DURATION = 8'd0,
    CFG_DENSITY  = 8'd1,
    CFG_SHAPE    = 8'd2,
    CFG_GATE     = 8'd3
  } cfg_idx_e;

  localparam logic [15:0] DUR_MIN    = 16'd512;
  localparam logic [15:0] DUR_MAX    = 16'd61440;
  localparam logic [13:0] DEN_MIN    = 14'd26;
  localparam logic [13:0] DEN_MAX    = 14'd8192;
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
  localparam logic [31:0] ONE_SECOND = 32'h0100_0000;

  // Roots 2^(-1/2^j) of one half, Q0.30
  typedef logic [16:0][29:0] exp_tab_t;

  // One write into the event length table
  typedef struct packed {
    logic        en;
    logic [15:0] addr;
    logic [31:0] data;
  } tbl_wr_t;

  // Build the root table by repeated integer square roots
  function automatic exp_tab_t exp_tab_calc();
    exp_tab_t    tab;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    tab[0] = 30'h2000_0000;
    for (int j = 1; j <= 16; j++) begin
      v   = {4'b0, tab[j-1], 30'b0};
      res = '0;
      bt  = 64'h4000_0000_0000_0000;
      for (int s = 0; s < 32; s++) begin
        if (v >= res + bt) begin
          v   = v - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
      tab[j] = res[29:0];
    end
    return tab;
  endfunction

endpackage

[design/wegs_if.sv]
interface wegs_in_if;
  logic        valid;
  logic        ready;
  logic        start_sequence;
  logic [23:0] tick_time;
  modport source (output valid, start_sequence, tick_time, input ready);
  modport sink (input valid, start_sequence, tick_time, output ready);
endinterface

interface wegs_out_if;
  logic valid;
  logic ready;
  logic gate;
  logic end_of_cycle;
  modport source (output valid, gate, end_of_cycle, input ready);
  modport sink (input valid, gate, end_of_cycle, output ready);
endinterface

interface wegs_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/warped_event_gate_sequencer_top.sv]
// Tick without start: table read, gate multiply, compare, output load (a tick
// past the last event skips to output load, which waits for a free output
// register); no new request is taken meanwhile. Start: each event runs a
// bit-serial ramp divider and the shared multiplier through the warp power.
// Reset clears control state and loads default configuration; the length
// table is undefined until the first start, and ticks before it give gate 0.
module warped_event_gate_sequencer_top #(
  parameter int unsigned MAX_EVENTS = 2048
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wegs_cfg_if.sink   cfg_i,
  wegs_in_if.sink    in_i,
  wegs_out_if.source out_o
);
  import wegs_pkg::*;

  localparam int unsigned CW = $clog2(MAX_EVENTS + 1);

  logic [15:0]   dur_q, shape_q, gate_q;
  logic [13:0]   den_q;
  logic          bld_start, bld_done;
  logic [CW-1:0] bld_count;
  tbl_wr_t       tbl_wr;

  assign cfg_i.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q   <= 16'd5120;
      den_q   <= 14'd1024;
      shape_q <= 16'd32768;
      gate_q  <= 16'd32768;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_DURATION: dur_q   <= cfg_i.data;
        CFG_DENSITY:  den_q   <= cfg_i.data[13:0];
        CFG_SHAPE:    shape_q <= cfg_i.data;
        CFG_GATE:     gate_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  wegs_build #(.MAX_EVENTS(MAX_EVENTS), .CW(CW)) u_build (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (bld_start),
    .dur_i   (dur_q),
    .den_i   (den_q),
    .shape_i (shape_q),
    .done_o  (bld_done),
    .count_o (bld_count),
    .wr_o    (tbl_wr)
  );

  wegs_play #(.MAX_EVENTS(MAX_EVENTS), .CW(CW)) u_play (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .gate_frac_i (gate_q),
    .bld_start_o (bld_start),
    .bld_done_i  (bld_done),
    .bld_count_i (bld_count),
    .wr_i        (tbl_wr)
  );

endmodule

[design/wegs_build.sv]
module wegs_build #(
  parameter int unsigned MAX_EVENTS = 2048,
  parameter int unsigned CW = $clog2(MAX_EVENTS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [15:0]      dur_i,
  input  logic [13:0]      den_i,
  input  logic [15:0]      shape_i,
  output logic             done_o,
  output logic [CW-1:0]    count_o,
  output wegs_pkg::tbl_wr_t wr_o
);
  import wegs_pkg::*;

  localparam int unsigned DW  = CW + 30;
  localparam int unsigned DCW = $clog2(DW + 1);
  localparam exp_tab_t EXP_TAB = exp_tab_calc();

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_COUNT = 16'h0002,
    S_EVT   = 16'h0004,
    S_DIV   = 16'h0008,
    S_POW   = 16'h0010,
    S_NORM  = 16'h0020,
    S_SQM   = 16'h0040,
    S_SQT   = 16'h0080,
    S_EXM   = 16'h0100,
    S_EXT   = 16'h0200,
    S_ACM   = 16'h0400,
    S_ACT   = 16'h0800,
    S_RES   = 16'h1000,
    S_TM    = 16'h2000,
    S_TT    = 16'h4000,
    S_LAST  = 16'h8000
  } bstate_e;

  bstate_e        state_q;
  logic [CW-1:0]  n_q, i_q, rem_q;
  logic [DW-1:0]  dvd_q;
  logic [DCW-1:0] dcnt_q;
  logic [30:0]    quo_q, m_q, acc_q, pw_q, prev_q;
  logic [4:0]     k_q;
  logic [15:0]    f_q;
  logic [3:0]     bcnt_q;
  logic [23:0]    e_q;
  logic [63:0]    prod_q;

  logic [15:0] dur_c;
  logic [13:0] den_c;
  logic [29:0] np;
  logic [31:0] n_ext;
  logic [CW-1:0] n_sel, div_val;
  logic        flip;
  logic [18:0] six_p, d_val;
  logic [30:0] xin, w_val, t_val, len_val;
  logic [20:0] l_val;
  logic [31:0] s_val;
  logic [CW:0] rs, rs_sub;
  logic        ge;
  logic [31:0] op_a, op_b;
  logic [63:0] prod_d;
  logic [CW-1:0] wa;

  // Clamp registers and derive the event count
  assign dur_c = (dur_i < DUR_MIN) ? DUR_MIN : ((dur_i > DUR_MAX) ? DUR_MAX : dur_i);
  assign den_c = (den_i < DEN_MIN) ? DEN_MIN : ((den_i > DEN_MAX) ? DEN_MAX : den_i);
  assign np    = 30'(dur_c) * 30'(den_c);
  assign n_ext = 32'(np[29:18]);
  assign n_sel = (n_ext == 32'd0) ? CW'(1) :
                 ((n_ext > 32'(MAX_EVENTS)) ? CW'(MAX_EVENTS) : n_ext[CW-1:0]);

  // Warp exponent in Q.16
  assign flip  = shape_i[15];
  assign six_p = {1'b0, shape_i, 2'b0} + {2'b0, shape_i, 1'b0};
  assign d_val = flip ? (six_p - 19'd131072) : (19'd262144 - six_p);

  // Ramp divider step
  assign div_val = n_q - CW'(1);
  assign rs      = {rem_q, dvd_q[DW-1]};
  assign ge      = rs >= {1'b0, div_val};
  assign rs_sub  = rs - {1'b0, div_val};

  assign xin     = flip ? (ONE_Q30 - quo_q) : quo_q;
  assign s_val   = prod_q[61:30];
  assign l_val   = {k_q, 16'b0} - {5'b0, f_q};
  assign w_val   = flip ? (ONE_Q30 - pw_q) : pw_q;
  assign t_val   = prod_q[46:16];
  assign len_val = (t_val >= prev_q) ? (t_val - prev_q) : '0;

  // Shared multiplier operands
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_q)
      S_SQM: begin
        op_a = {1'b0, m_q};
        op_b = {1'b0, m_q};
      end
      S_EXM: begin
        op_a = 32'(l_val);
        op_b = 32'(d_val);
      end
      S_ACM: begin
        op_a = {1'b0, acc_q};
        op_b = {2'b0, EXP_TAB[5'(bcnt_q) + 5'd1]};
      end
      S_TM: begin
        op_a = {16'b0, dur_c};
        op_b = {1'b0, w_val};
      end
      default: ;
    endcase
  end

  assign prod_d = 64'(op_a) * 64'(op_b);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // Table write port
  assign wa         = (state_q == S_LAST) ? div_val : (i_q - CW'(1));
  assign wr_o.en    = (state_q == S_LAST) || ((state_q == S_TT) && (i_q != '0));
  assign wr_o.addr  = 16'(wa);
  assign wr_o.data  = (state_q == S_LAST) ? ONE_SECOND : {1'b0, len_val};
  assign done_o     = (state_q == S_LAST);
  assign count_o    = n_q;

  // Build sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      n_q     <= '0;
      i_q     <= '0;
      rem_q   <= '0;
      dvd_q   <= '0;
      dcnt_q  <= '0;
      quo_q   <= '0;
      m_q     <= '0;
      acc_q   <= '0;
      pw_q    <= '0;
      prev_q  <= '0;
      k_q     <= '0;
      f_q     <= '0;
      bcnt_q  <= '0;
      e_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) state_q <= S_COUNT;
        end
        S_COUNT: begin
          n_q     <= n_sel;
          i_q     <= '0;
          prev_q  <= '0;
          state_q <= S_EVT;
        end
        S_EVT: begin
          quo_q <= '0;
          if (n_q == CW'(1)) begin
            state_q <= S_POW;
          end else begin
            rem_q   <= '0;
            dvd_q   <= {i_q, 30'b0};
            dcnt_q  <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q <= ge ? rs_sub[CW-1:0] : rs[CW-1:0];
          quo_q <= {quo_q[29:0], ge};
          dvd_q <= {dvd_q[DW-2:0], 1'b0};
          if (dcnt_q == DCW'(DW - 1)) state_q <= S_POW;
          else dcnt_q <= dcnt_q + DCW'(1);
        end
        S_POW: begin
          if (xin == '0) begin
            pw_q    <= '0;
            state_q <= S_TM;
          end else if (xin[30]) begin
            pw_q    <= ONE_Q30;
            state_q <= S_TM;
          end else begin
            m_q     <= xin;
            k_q     <= '0;
            state_q <= S_NORM;
          end
        end
        S_NORM: begin
          if (m_q[30]) begin
            f_q     <= '0;
            bcnt_q  <= '0;
            state_q <= S_SQM;
          end else begin
            m_q <= {m_q[29:0], 1'b0};
            k_q <= k_q + 5'd1;
          end
        end
        S_SQM: state_q <= S_SQT;
        S_SQT: begin
          if (s_val[31]) begin
            m_q <= s_val[31:1];
            f_q <= {f_q[14:0], 1'b1};
          end else begin
            m_q <= s_val[30:0];
            f_q <= {f_q[14:0], 1'b0};
          end
          if (bcnt_q == 4'd15) begin
            state_q <= S_EXM;
          end else begin
            bcnt_q  <= bcnt_q + 4'd1;
            state_q <= S_SQM;
          end
        end
        S_EXM: state_q <= S_EXT;
        S_EXT: begin
          e_q     <= prod_q[39:16];
          acc_q   <= ONE_Q30;
          bcnt_q  <= '0;
          state_q <= S_ACM;
        end
        S_ACM: begin
          if (e_q[~bcnt_q]) state_q <= S_ACT;
          else if (bcnt_q == 4'd15) state_q <= S_RES;
          else bcnt_q <= bcnt_q + 4'd1;
        end
        S_ACT: begin
          acc_q <= prod_q[60:30];
          if (bcnt_q == 4'd15) begin
            state_q <= S_RES;
          end else begin
            bcnt_q  <= bcnt_q + 4'd1;
            state_q <= S_ACM;
          end
        end
        S_RES: begin
          pw_q    <= (e_q[23:16] >= 8'd31) ? '0 : (acc_q >> e_q[23:16]);
          state_q <= S_TM;
        end
        S_TM: state_q <= S_TT;
        S_TT: begin
          prev_q <= t_val;
          if (i_q == div_val) begin
            state_q <= S_LAST;
          end else begin
            i_q     <= i_q + CW'(1);
            state_q <= S_EVT;
          end
        end
        S_LAST: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[design/wegs_play.sv]
module wegs_play #(
  parameter int unsigned MAX_EVENTS = 2048,
  parameter int unsigned CW = $clog2(MAX_EVENTS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  wegs_in_if.sink           in_i,
  wegs_out_if.source        out_o,
  input  logic [15:0]       gate_frac_i,
  output logic              bld_start_o,
  input  logic              bld_done_i,
  input  logic [CW-1:0]     bld_count_i,
  input  wegs_pkg::tbl_wr_t wr_i
);
  import wegs_pkg::*;

  localparam int unsigned AW = $clog2(MAX_EVENTS);

  typedef enum logic [5:0] {
    P_IDLE  = 6'b000001,
    P_BUILD = 6'b000010,
    P_READ  = 6'b000100,
    P_MUL   = 6'b001000,
    P_CMP   = 6'b010000,
    P_OUT   = 6'b100000
  } pstate_e;

  pstate_e       state_q;
  logic [31:0]   mem_q [MAX_EVENTS];
  logic [31:0]   rd_q;
  logic [23:0]   tick_q;
  logic [CW-1:0] count_q, cur_q;
  logic [31:0]   phase_q;
  logic [47:0]   gprod_q;
  logic          res_gate_q, res_eoc_q;
  logic          out_valid_q, out_gate_q, out_eoc_q;

  logic          active, gate_now, ends, out_free;
  logic [32:0]   sum;
  logic [CW-1:0] cur_inc;

  assign in_i.ready        = (state_q == P_IDLE);
  assign bld_start_o       = (state_q == P_BUILD);
  assign out_o.valid        = out_valid_q;
  assign out_o.gate         = out_gate_q;
  assign out_o.end_of_cycle = out_eoc_q;

  assign active   = cur_q < count_q;
  assign sum      = {1'b0, phase_q} + 33'(tick_q);
  assign gate_now = {phase_q, 16'b0} < gprod_q;
  assign ends     = sum >= {1'b0, rd_q};
  assign cur_inc  = cur_q + CW'(1);
  assign out_free = !out_valid_q || out_o.ready;

  // Event length table
  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem_q[wr_i.addr[AW-1:0]] <= wr_i.data;
    rd_q <= mem_q[cur_q[AW-1:0]];
  end

  // Tick sequencer with output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= P_IDLE;
      tick_q      <= '0;
      count_q     <= '0;
      cur_q       <= '0;
      phase_q     <= '0;
      gprod_q     <= '0;
      res_gate_q  <= 1'b0;
      res_eoc_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_gate_q  <= 1'b0;
      out_eoc_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != P_OUT)) out_valid_q <= 1'b0;
      unique case (state_q)
        P_IDLE: begin
          if (in_i.valid) begin
            tick_q  <= in_i.tick_time;
            state_q <= in_i.start_sequence ? P_BUILD : P_READ;
          end
        end
        P_BUILD: begin
          if (bld_done_i) begin
            count_q <= bld_count_i;
            cur_q   <= '0;
            phase_q <= '0;
            state_q <= P_READ;
          end
        end
        P_READ: begin
          if (active) begin
            state_q <= P_MUL;
          end else begin
            res_gate_q <= 1'b0;
            res_eoc_q  <= 1'b0;
            state_q    <= P_OUT;
          end
        end
        P_MUL: begin
          gprod_q <= 48'(rd_q) * 48'(gate_frac_i);
          state_q <= P_CMP;
        end
        P_CMP: begin
          res_gate_q <= gate_now;
          if (ends) begin
            cur_q     <= cur_inc;
            phase_q   <= '0;
            res_eoc_q <= (cur_inc == count_q);
          end else begin
            phase_q   <= sum[31:0];
            res_eoc_q <= 1'b0;
          end
          state_q <= P_OUT;
        end
        P_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_gate_q  <= res_gate_q;
            out_eoc_q   <= res_eoc_q;
            state_q     <= P_IDLE;
          end
        end
        default: state_q <= P_IDLE;
      endcase
    end
  end

endmodule

[bench/wegs_checker.sv]
module wegs_checker #(
  parameter int unsigned MAX_EVENTS = 2048
) (
  input  logic clk_i,
  input  logic rst_ni,
  wegs_cfg_if  cfg_mon,
  wegs_in_if   tick_mon,
  wegs_out_if  res_mon,
  output int   fail_cnt_o,
  output int   pending_o
);
  import wegs_pkg::*;

  localparam longint unsigned UNIT_Q30 = 64'd1 << 30;

  typedef struct packed {
    logic gate;
    logic end_of_cycle;
  } gate_res_t;

  longint unsigned root_tab[17];
  logic [31:0]     len_tab[MAX_EVENTS];
  int unsigned     n_events;
  int unsigned     ev_idx;
  logic [31:0]     ev_phase;
  logic [15:0]     dur_reg;
  logic [13:0]     den_reg;
  logic [15:0]     shape_reg;
  logic [15:0]     frac_reg;
  gate_res_t       gate_q[$];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bt;
    res = 0;
    bt  = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // Fill the fractional power-of-two roots once
  initial begin
    root_tab[0] = UNIT_Q30 >> 1;
    for (int j = 1; j <= 16; j++) root_tab[j] = int_sqrt(root_tab[j-1] << 30);
  end

  // x^d in Q0.30 through a log2 by squaring and an exp from the root table
  function automatic longint unsigned warp_pow(longint unsigned x, longint unsigned d);
    longint unsigned m, f, l, e, q, r, acc;
    int unsigned k;
    if (x == 0) return 0;
    if (x >= UNIT_Q30) return UNIT_Q30;
    m = x;
    k = 0;
    while (m < UNIT_Q30) begin
      m = m << 1;
      k++;
    end
    f = 0;
    for (int b = 15; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (UNIT_Q30 << 1)) begin
        m = m >> 1;
        f = f | (64'd1 << b);
      end
    end
    l   = (longint'(k) << 16) - f;
    e   = (l * d) >> 16;
    q   = e >> 16;
    r   = e & 64'hFFFF;
    acc = UNIT_Q30;
    for (int b = 15; b >= 0; b--) begin
      if (r[b]) acc = (acc * root_tab[16-b]) >> 30;
    end
    if (q >= 31) return 0;
    return acc >> q;
  endfunction

  // Rebuild the event length table and restart the sequence
  task automatic rebuild_events();
    longint unsigned dur, den, n, p, d, x, w, t, prev;
    dur = (dur_reg < DUR_MIN) ? DUR_MIN : ((dur_reg > DUR_MAX) ? DUR_MAX : dur_reg);
    den = (den_reg < DEN_MIN) ? DEN_MIN : ((den_reg > DEN_MAX) ? DEN_MAX : den_reg);
    n   = (dur * den) >> 18;
    p   = shape_reg;
    d   = (p < 32768) ? (262144 - 6 * p) : (6 * p - 131072);
    if (n < 1) n = 1;
    if (n > MAX_EVENTS) n = MAX_EVENTS;
    prev = 0;
    for (longint unsigned i = 0; i < n; i++) begin
      x = (n > 1) ? ((i << 30) / (n - 1)) : 0;
      w = (p < 32768) ? warp_pow(x, d) : UNIT_Q30 - warp_pow(UNIT_Q30 - x, d);
      t = (dur * w) >> 16;
      if (i > 0) len_tab[i-1] = (t >= prev) ? 32'(t - prev) : 32'd0;
      prev = t;
    end
    len_tab[n-1] = ONE_SECOND;
    n_events = int'(n);
    ev_idx   = 0;
    ev_phase = '0;
  endtask

  // Advance one tick and work out its gate and end flag
  function automatic gate_res_t advance_tick(logic [23:0] tick);
    gate_res_t       res;
    longint unsigned len, ph;
    res = '0;
    if (ev_idx >= n_events || ev_idx >= MAX_EVENTS) return res;
    len = len_tab[ev_idx];
    ph  = ev_phase;
    res.gate = ((ph << 16) < len * longint'(frac_reg));
    ph = ph + tick;
    if (ph >= len) begin
      ev_idx++;
      if (ev_idx == n_events) res.end_of_cycle = 1'b1;
      ph = 0;
    end
    ev_phase = 32'(ph);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic got, logic want);
    $display("mismatch %s: got %0b want %0b at %0t", what, got, want, $time);
    fail_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    gate_res_t want;
    if (!rst_ni) begin
      dur_reg    = 16'd5120;
      den_reg    = 14'd1024;
      shape_reg  = 16'd32768;
      frac_reg   = 16'd32768;
      n_events   = 0;
      ev_idx     = 0;
      ev_phase   = '0;
      fail_cnt_o = 0;
      pending_o  = 0;
    end else begin
      // Track register writes
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_DURATION: dur_reg   = cfg_mon.data;
          CFG_DENSITY:  den_reg   = cfg_mon.data[13:0];
          CFG_SHAPE:    shape_reg = cfg_mon.data;
          CFG_GATE:     frac_reg  = cfg_mon.data;
          default: ;
        endcase
      end
      // Predict each accepted tick
      if (tick_mon.valid && tick_mon.ready) begin
        if (tick_mon.start_sequence) rebuild_events();
        gate_q.push_back(advance_tick(tick_mon.tick_time));
      end
      // Compare each accepted result with the oldest prediction
      if (res_mon.valid && res_mon.ready) begin
        if (gate_q.size() == 0) begin
          report_mismatch("result with no request waiting", 1'b1, 1'b0);
        end else begin
          want = gate_q.pop_front();
          if (res_mon.gate !== want.gate) report_mismatch("gate", res_mon.gate, want.gate);
          if (res_mon.end_of_cycle !== want.end_of_cycle)
            report_mismatch("end_of_cycle", res_mon.end_of_cycle, want.end_of_cycle);
        end
      end
      pending_o = gate_q.size();
    end
  end

endmodule

[bench/warped_event_gate_sequencer_top_tb.sv]
module warped_event_gate_sequencer_top_tb;
  import wegs_pkg::*;

  localparam int          CYCLE_LIMIT  = 4000000;
  localparam int          RAND_TICKS   = 630;
  localparam logic [7:0]  CFG_UNMAPPED = 8'd9;

  logic clk;
  logic rst_n;
  int   fail_cnt;
  int   pending;
  int   cycles;
  int   n_ticks;
  int   n_starts;
  int   n_writes;
  bit   idle_en;
  bit   long_stall;

  wegs_cfg_if cfg_if ();
  wegs_in_if  in_if ();
  wegs_out_if out_if ();

  warped_event_gate_sequencer_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  wegs_checker chk (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_mon    (cfg_if),
    .tick_mon   (in_if),
    .res_mon    (out_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[warped_event_gate_sequencer_top] ERROR");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_stall) begin
        long_stall = 1'b0;
        out_if.ready <= 1'b0;
        repeat (300) @(posedge clk);
        out_if.ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic cfg_write(logic [7:0] idx, logic [15:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    n_writes++;
  endtask

  task automatic send_tick(logic start, logic [23:0] tick);
    in_if.valid          <= 1'b1;
    in_if.start_sequence <= start;
    in_if.tick_time      <= tick;
    do @(posedge clk); while (!in_if.ready);
    n_ticks++;
    if (start) n_starts++;
    // Hold off the next request now and then
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    logic [15:0] dur;
    logic [13:0] den;
    logic [23:0] tick;
    int          len;
    int          phase_no;
    cycles       = 0;
    n_ticks      = 0;
    n_starts     = 0;
    n_writes     = 0;
    idle_en      = 1'b1;
    long_stall   = 1'b0;
    rst_n        = 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CFG_DURATION;
    cfg_if.data  <= '0;
    in_if.valid  <= 1'b0;
    in_if.start_sequence <= 1'b0;
    in_if.tick_time      <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Ticks before any start stay idle
    send_tick(1'b0, 24'd0);
    send_tick(1'b0, 24'hFFFFFF);
    // Default settings, zero tick first, then eight largest ticks, one event each
    send_tick(1'b1, 24'd0);
    repeat (8) send_tick(1'b0, 24'hFFFFFF);
    wait_drained();

    // Low extremes: single event, steep warp, gate never open
    cfg_write(CFG_DURATION, 16'd0);
    cfg_write(CFG_DENSITY, 16'd0);
    cfg_write(CFG_SHAPE, 16'd0);
    cfg_write(CFG_GATE, 16'd0);
    cfg_write(CFG_UNMAPPED, 16'hFFFF);
    send_tick(1'b1, 24'd1);
    send_tick(1'b0, 24'hFFFFFF);
    send_tick(1'b0, 24'hFFFFFF);
    wait_drained();

    // High extremes: largest table, steepest warp, gate nearly always open
    cfg_write(CFG_DURATION, 16'hFFFF);
    cfg_write(CFG_DENSITY, 16'hFFFF);
    cfg_write(CFG_SHAPE, 16'hFFFF);
    cfg_write(CFG_GATE, 16'hFFFF);
    send_tick(1'b1, 24'd0);
    send_tick(1'b0, 24'd1);
    send_tick(1'b0, 24'hFFFFFF);
    send_tick(1'b0, 24'h000FFF);
    wait_drained();

    // Random phases with a restart at the head of each
    phase_no = 0;
    while (n_ticks < RAND_TICKS) begin
      if ($urandom_range(0, 9) == 0) begin
        den = 14'($urandom);
        dur = 16'($urandom_range(0, 2048));
      end else begin
        den = 14'($urandom_range(0, 400));
        dur = 16'($urandom);
      end
      cfg_write(CFG_DURATION, dur);
      cfg_write(CFG_DENSITY, {2'($urandom), den});
      if ($urandom_range(0, 1)) cfg_write(CFG_SHAPE, 16'($urandom));
      if ($urandom_range(0, 1)) cfg_write(CFG_GATE, 16'($urandom));
      if (n_ticks > RAND_TICKS - 100) idle_en = 1'b0;
      len = $urandom_range(25, 60);
      for (int i = 0; i < len; i++) begin
        if (phase_no == 2 && i == 8) long_stall = 1'b1;
        if (phase_no == 4 && i == 20) wait_drained();
        case ($urandom_range(0, 3))
          0:       tick = 24'($urandom);
          1:       tick = 24'($urandom_range(0, 1 << 20));
          2:       tick = 24'($urandom_range(0, 1 << 14));
          default: tick = 24'hFFFFFF - 24'($urandom_range(0, 255));
        endcase
        send_tick(i == 0 || $urandom_range(0, 39) == 0, tick);
      end
      wait_drained();
      phase_no++;
    end

    in_if.valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d ticks with %0d restarts over %0d register writes",
             n_ticks, n_starts, n_writes);
    $display("included idle ticks, extreme settings and a long result-side stall");
    if (fail_cnt == 0) begin
      $display("[warped_event_gate_sequencer_top] OK");
    end else begin
      $display("[warped_event_gate_sequencer_top] ERROR");
    end
    $finish;
  end

endmodule
